// ===== design/sab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the ascending sort block and its cells.
// ----------------------------------------------------------------------------
package sab_pkg;

   localparam int SORT_DEPTH = 64;
   localparam int DATA_W     = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // what the chain does in a cycle
   typedef struct packed {
      logic     insert;
      logic     shift;
      data_type new_value;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      data_type value;
      logic     occ;
      logic     gt;
   } cell_link_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

// ===== design/sab_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_cell
// One cell of the sorting chain: holds one element and its occupied flag.
// Insert moves larger elements one place right, drain moves all one place left.
// ----------------------------------------------------------------------------
module sab_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sab_pkg::cell_ctrl_type ctrl,
   input  sab_pkg::cell_link_type left_link,
   input  sab_pkg::cell_link_type right_link,
   output sab_pkg::cell_link_type own_link
);

   sab_pkg::data_type value_ff, value_in;
   logic              occ_ff, occ_in;
   logic              gt;

   // empty cells count as larger than anything, equal values stay in front
   assign gt = !occ_ff || (value_ff > ctrl.new_value);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      priority if (ctrl.shift) begin
         value_in = right_link.value;
         occ_in   = right_link.occ;
      end else if (ctrl.insert) begin
         if (gt) begin
            value_in = left_link.gt ? left_link.value : ctrl.new_value;
         end
         occ_in = occ_ff | left_link.occ;
      end else begin
         value_in = value_ff;
         occ_in   = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign own_link.value = value_ff;
   assign own_link.occ   = occ_ff;
   assign own_link.gt    = gt;

endmodule

// ===== design/sort_ascending_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_ascending_block
// Streaming stable ascending sorter built from a chain of insertion cells.
//
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_item_value, req_is_final
// rsp     | out       | rsp_valid, rsp_ready, rsp_sorted_value, rsp_end_of_list
//
// Loading takes an element whenever req is valid: every cell compares in parallel.
// After the final element the chain drains one result per cycle from cell 0.
// No element is taken while draining; a stalled rsp holds the chain.
// Reset empties the chain at once, no clearing pass.
// Elements beyond 64 are dropped; a final one still starts the drain.
// ----------------------------------------------------------------------------
module sort_ascending_block (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_item_value,
   input  logic                req_is_final,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_sorted_value,
   output logic                rsp_end_of_list
);

   localparam int DEPTH = sab_pkg::SORT_DEPTH;

   sab_pkg::state_type     state_ff, state_in;
   sab_pkg::cell_ctrl_type ctrl;
   sab_pkg::cell_link_type links [DEPTH];
   sab_pkg::cell_link_type edge_left, edge_right;
   logic [DEPTH-1:0]       occ_vec;
   logic [DEPTH-2:0]       order_ok;
   logic                   req_xfer, rsp_xfer, full;

   assign edge_left  = '{value: '0, occ: 1'b1, gt: 1'b0};
   assign edge_right = '{value: '0, occ: 1'b0, gt: 1'b1};

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign full     = occ_vec[DEPTH-1];

   assign ctrl.insert    = req_xfer && !full;
   assign ctrl.shift     = rsp_xfer;
   assign ctrl.new_value = req_item_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sab_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i-1]),
         .right_link ((i == DEPTH-1) ? edge_right : links[(i == DEPTH-1) ? i : i+1]),
         .own_link   (links[i])
      );
      assign occ_vec[i] = links[i].occ;
   end

   for (genvar i = 0; i < DEPTH-1; i++) begin : g_order
      assign order_ok[i] = !links[i+1].occ || (links[i].value <= links[i+1].value);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sab_pkg::ST_LOAD: begin
            if (req_xfer && req_is_final) begin
               state_in = sab_pkg::ST_DRAIN;
            end
         end
         sab_pkg::ST_DRAIN: begin
            if (rsp_xfer && !links[1].occ) begin
               state_in = sab_pkg::ST_LOAD;
            end
         end
         default: state_in = sab_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sab_pkg::ST_LOAD:  req_ready = 1'b1;
         sab_pkg::ST_DRAIN: rsp_valid = links[0].occ;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_sorted_value = links[0].value;
   assign rsp_end_of_list  = !links[1].occ;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sab_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // occupied cells always form a prefix of the chain
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (occ_vec & (occ_vec + 1'b1)) == '0)
      else $error("occupied cells not contiguous");

   // stored elements stay in ascending order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("chain out of order");

   // draining always has something to show
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == sab_pkg::ST_DRAIN |-> links[0].occ)
      else $error("drain with empty chain");

   // the last result empties the chain and reopens loading
   a_end_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_end_of_list |=> !links[0].occ && req_ready)
      else $error("chain not empty after last result");

   // a final transfer always leads to a drain
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_is_final |=> rsp_valid)
      else $error("no result after final element");

endmodule

// ===== test/tb_sort_ascending_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sort_ascending_block
// Sends lists of signed words with a final mark on the last one, keeps a
// stable-sort model of the pending list and checks every sorted word and
// its end mark against the model, in order. Covers word extremes, ties,
// single-element lists, full and overfull lists, and random lists with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sort_ascending_block;

   localparam int CLOCK_HIGH_NS = 6;
   localparam int CLOCK_LOW_NS  = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 100;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      sab_pkg::data_type value;
      logic              last;
   } sorted_word_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   sab_pkg::data_type req_item_value  = '0;
   logic              req_is_final    = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   sab_pkg::data_type rsp_sorted_value;
   logic              rsp_end_of_list;

   sab_pkg::data_type pending_list[$];
   sorted_word_type   sorted_due[$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                items_sent     = 0;
   int                stall_left     = 0;
   bit                req_pacing     = 1'b1;
   bit                rsp_stalling   = 1'b1;

   sort_ascending_block i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item_value   (req_item_value),
      .req_is_final     (req_is_final),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_list  (rsp_end_of_list)
   );

   always begin
      #CLOCK_HIGH_NS clock = 1'b1;
      #CLOCK_LOW_NS  clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[sort_ascending_block] ERROR");
         $finish;
      end
   end

   // stable ascending order of the pending list, queued when the final mark comes
   function automatic void take_element(input sab_pkg::data_type value,
                                        input logic final_mark);
      sab_pkg::data_type work[$];
      sab_pkg::data_type held;
      sorted_word_type   word;
      int                i;
      int                j;
      if (pending_list.size() < sab_pkg::SORT_DEPTH) pending_list = {pending_list, value};
      if (!final_mark) return;
      work = pending_list;
      for (i = 1; i < work.size(); i++) begin
         held = work[i];
         j = i;
         while (j > 0 && work[j-1] > held) begin
            work[j] = work[j-1];
            j--;
         end
         work[j] = held;
      end
      for (i = 0; i < work.size(); i++) begin
         word.value = work[i];
         word.last  = (i == work.size() - 1);
         sorted_due = {sorted_due, word};
      end
      pending_list.delete();
   endfunction

   // request transfers feed the model before result transfers are checked
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) take_element(req_item_value, req_is_final);
         if (rsp_valid && rsp_ready) begin
            if (sorted_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result: value %0d last %0b",
                           rsp_sorted_value, rsp_end_of_list);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_sorted_value !== want.value || rsp_end_of_list !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                              want.value, want.last, rsp_sorted_value, rsp_end_of_list);
               end
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (!req_pacing) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   always @(negedge clock) begin
      if (rsp_stalling && stall_left == 0 && $urandom_range(0, 3) == 0)
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30);
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic send_item(input sab_pkg::data_type value, input logic final_mark);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_item_value = value;
      req_is_final   = final_mark;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_list(input sab_pkg::data_type values[$]);
      int i;
      for (i = 0; i < values.size(); i++) send_item(values[i], i == values.size() - 1);
   endtask

   // hold off the sender until every sorted word has come out
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sorted_due.size() != 0) @(negedge clock);
   endtask

   function automatic sab_pkg::data_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return sab_pkg::data_type'($urandom());
      if (r < 75) return sab_pkg::data_type'($signed($urandom_range(0, 8)) - 4);
      if (r < 90) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0001;
            3: return 32'sh7FFF_FFFE;
            4: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return sab_pkg::data_type'($signed(8'($urandom())));
   endfunction

   task automatic test_extremes();
      send_list('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA});
   endtask

   task automatic test_single_elements();
      send_list('{32'sh8000_0000});
      send_list('{32'sh7FFF_FFFF});
      send_list('{32'sd0});
   endtask

   task automatic test_ties();
      send_list('{32'sd5, 32'sd5, -32'sd5, 32'sd5, -32'sd5, 32'sd0});
      send_list('{32'sd3, 32'sd2, 32'sd1});
   endtask

   // full list, final dropped at capacity, and extra words past capacity
   task automatic test_capacity();
      sab_pkg::data_type values[$];
      int                extra;
      int                i;
      for (extra = 0; extra <= 5; extra += 5) begin
         values.delete();
         for (i = 0; i < sab_pkg::SORT_DEPTH + extra; i++) values = {values, pick_value()};
         send_list(values);
      end
      values.delete();
      for (i = 0; i < sab_pkg::SORT_DEPTH + 1; i++) values = {values, pick_value()};
      send_list(values);
      wait_drained();
   endtask

   task automatic test_random_lists();
      sab_pkg::data_type values[$];
      int                start_count;
      int                len;
      int                r;
      int                i;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         req_pacing   = ($urandom_range(0, 3) != 0);
         rsp_stalling = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 78)      len = $urandom_range(1, 12);
         else if (r < 92) len = $urandom_range(13, sab_pkg::SORT_DEPTH - 1);
         else if (r < 96) len = sab_pkg::SORT_DEPTH;
         else             len = $urandom_range(sab_pkg::SORT_DEPTH + 1,
                                               sab_pkg::SORT_DEPTH + 6);
         values.delete();
         for (i = 0; i < len; i++) values = {values, pick_value()};
         send_list(values);
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_single_elements();
      test_ties();
      wait_drained();
      req_pacing   = 1'b0;
      rsp_stalling = 1'b0;
      test_capacity();
      test_random_lists();
      wait_drained();
      repeat (2 * sab_pkg::SORT_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && sorted_due.size() == 0) begin
         $display("[sort_ascending_block] OK");
      end else begin
         $display("[sort_ascending_block] ERROR");
      end
      $finish;
   end

endmodule
